// ===== hdl/nmea_gga_position_parser_top_macros.svh =====
// assertion macros for the gga parser; they rely on signals named clock and reset
`ifndef NMEA_GGA_POSITION_PARSER_TOP_MACROS_SVH
`define NMEA_GGA_POSITION_PARSER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every edge outside reset
`define NGP_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("ngp check failed: lbl");
// consequent holds in the cycle after the antecedent
`define NGP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ngp check failed: lbl");
`else
`define NGP_ASSERT_ALWAYS(lbl, cond)
`define NGP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/ngp_pkg.sv =====
package ngp_pkg;

   localparam int LINE_MAX_DEFAULT = 127;

   // characters
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_COMMA  = 8'h2C;
   localparam logic [7:0] CHR_DOT    = 8'h2E;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_S      = 8'h53;
   localparam logic [7:0] CHR_W      = 8'h57;

   // saturation limits
   localparam logic [19:0] INT_SAT  = 20'd1048575;
   localparam logic [13:0] DEG_SAT  = 14'd10485;
   localparam logic [6:0]  MM_SAT   = 7'd75;
   localparam logic [29:0] TIME_SAT = 30'd999999999;
   localparam logic [30:0] LAT_SAT  = 31'd900000000;
   localparam logic [30:0] LON_SAT  = 31'd1800000000;

   // field numbers
   localparam logic [3:0] FIELD_TIME = 4'd2;
   localparam logic [3:0] FIELD_LAT  = 4'd3;
   localparam logic [3:0] FIELD_NS   = 4'd4;
   localparam logic [3:0] FIELD_LON  = 4'd5;
   localparam logic [3:0] FIELD_EW   = 4'd6;
   localparam logic [3:0] FIELD_FIX  = 4'd7;
   localparam logic [3:0] FIELD_SAT  = 4'd8;
   localparam logic [3:0] FIELD_MAX  = 4'd15;

   localparam logic [2:0] MATCH_LEN = 3'd6;

   typedef enum logic [1:0] {
      KIND_TIME,
      KIND_LAT,
      KIND_LON
   } kind_type;

   typedef struct packed {
      logic        match;
      logic [6:0]  mask;
      logic        south;
      logic        west;
      logic [3:0]  fix;
      logic [6:0]  sat;
   } commit_type;

   typedef struct packed {
      logic        fin;
      logic        nl;
      kind_type    kind;
      logic [19:0] int_val;
      logic [13:0] deg;
      logic [6:0]  mm;
      logic [16:0] frac;
      logic [2:0]  k;
      logic [9:0]  tfrac;
      commit_type  cmt;
   } stage1_type;

   typedef struct packed {
      logic        fin;
      logic        nl;
      kind_type    kind;
      logic [23:0] m5;
      logic [37:0] degterm;
      logic [30:0] tprod;
      commit_type  cmt;
   } stage2_type;

   typedef struct packed {
      logic        fin;
      logic        nl;
      kind_type    kind;
      logic [24:0] q;
      logic [37:0] degterm;
      logic [29:0] tsat;
      commit_type  cmt;
   } stage3_type;

   function automatic logic [7:0] pattern_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h24;
         3'd1:    c = 8'h47;
         3'd2:    c = 8'h4E;
         3'd3:    c = 8'h47;
         3'd4:    c = 8'h47;
         3'd5:    c = 8'h41;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // scale of a k-digit fraction to units of 1e-5
   function automatic logic [16:0] pow10_frac(input logic [2:0] k);
      logic [16:0] p;
      unique case (k)
         3'd0:    p = 17'd100000;
         3'd1:    p = 17'd10000;
         3'd2:    p = 17'd1000;
         3'd3:    p = 17'd100;
         3'd4:    p = 17'd10;
         default: p = 17'd1;
      endcase
      return p;
   endfunction

   // scale of the first fraction digits to milliseconds
   function automatic logic [9:0] time_scale(input logic [2:0] k);
      logic [9:0] p;
      unique case (k)
         3'd0:    p = 10'd1000;
         3'd1:    p = 10'd100;
         3'd2:    p = 10'd10;
         default: p = 10'd1;
      endcase
      return p;
   endfunction

endpackage

// ===== hdl/nmea_gga_position_parser_top.sv =====
// channel | direction | ports
// request | in        | req_valid, req_ready, req_rx_byte
// result  | out       | rsp_valid, rsp_ready, rsp_utc_time_milli, rsp_latitude_e7,
//         |           | rsp_longitude_e7, rsp_fix_quality, rsp_satellite_count
// one byte is taken per cycle while req_ready is high; line state updates in the cycle a byte is taken
// a result leaves through three conversion stages, then the output register; the depth
// is set by the multiply and divide-by-3 chain of the position
// reset is synchronous and clears line state and published values
// only a newline of a matching line held at the last stage, while an earlier result is
// still not taken, stalls the pipe and drops req_ready
`include "nmea_gga_position_parser_top_macros.svh"

module nmea_gga_position_parser_top #(
   parameter int LINE_MAX = ngp_pkg::LINE_MAX_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [29:0]        rsp_utc_time_milli,
   output logic signed [30:0] rsp_latitude_e7,
   output logic signed [31:0] rsp_longitude_e7,
   output logic [3:0]         rsp_fix_quality,
   output logic [6:0]         rsp_satellite_count
);
   import ngp_pkg::*;

   localparam int CW = $clog2(LINE_MAX + 1);

   // line state
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [3:0]    field_ff, field_in;
   logic [2:0]    mprog_ff, mprog_in;
   logic          mfound_ff, mfound_in;
   logic [19:0]   int_ff, int_in;
   logic [13:0]   deg_ff, deg_in;
   logic [6:0]    mm_ff, mm_in;
   logic [16:0]   frac_ff, frac_in;
   logic [2:0]    k_ff, k_in;
   logic [9:0]    tfrac_ff, tfrac_in;
   logic          point_ff, point_in;
   logic          ended_ff, ended_in;
   logic [6:0]    mask_ff, mask_in;
   logic          south_ff, south_in;
   logic          west_ff, west_in;
   logic [3:0]    fix_ff, fix_in;
   logic [6:0]    sat_ff, sat_in;

   // pipeline and outputs
   stage1_type    s1_ff, s1_in;
   stage2_type    s2_ff, s2_in;
   stage3_type    s3_ff, s3_in;
   logic [29:0]   shtime_ff, shtime_in;
   logic [29:0]   shlat_ff, shlat_in;
   logic [30:0]   shlon_ff, shlon_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [29:0]   pubtime_ff, pubtime_in;
   logic [30:0]   publat_ff, publat_in;
   logic [31:0]   publon_ff, publon_in;
   logic [3:0]    pubfix_ff, pubfix_in;
   logic [6:0]    pubsat_ff, pubsat_in;

   logic          stall;
   logic          accept;
   logic          in_range;
   logic [2:0]    fidx;
   logic          fin_active;
   logic [3:0]    fix_fin;
   logic [6:0]    sat_fin;
   logic [2:0]    mnext;
   logic [3:0]    dig;
   logic          is_digit;
   logic [23:0]   int_mul;
   logic [14:0]   tens_prod;
   logic [3:0]    tens;
   logic [6:0]    ones;
   logic [26:0]   n3;
   logic [53:0]   q_prod;
   logic [19:0]   tf_prod;
   logic [37:0]   total;
   logic [30:0]   limit;
   logic [30:0]   posv;
   logic [29:0]   time_cur;
   logic [29:0]   lat_cur;
   logic [30:0]   lon_cur;
   logic          commit;

   assign stall     = s3_ff.nl && s3_ff.cmt.match && rsp_valid_ff && !rsp_ready;
   assign req_ready = !stall;
   assign accept    = req_valid && req_ready;

   // finish of the field in progress
   assign in_range   = (field_ff >= FIELD_TIME) && (field_ff <= FIELD_SAT);
   assign fidx       = 3'(field_ff - FIELD_TIME);
   assign fin_active = in_range && mask_ff[fidx];
   assign fix_fin    = (int_ff > 20'd15) ? 4'd15 : int_ff[3:0];
   assign sat_fin    = (int_ff > 20'd99) ? 7'd99 : int_ff[6:0];

   // digit helpers
   assign is_digit  = (req_rx_byte >= CHR_ZERO) && (req_rx_byte <= CHR_NINE);
   assign dig       = 4'(req_rx_byte - CHR_ZERO);
   assign int_mul   = {4'b0, int_ff} * 24'd10 + {20'b0, dig};
   assign tens_prod = {8'b0, mm_ff} * 15'd205;
   assign tens      = tens_prod[14:11];
   assign ones      = 7'(mm_ff - {3'b0, tens} * 7'd10);
   assign mnext     = (req_rx_byte == pattern_char(mprog_ff)) ? 3'(mprog_ff + 3'd1) :
                      ((req_rx_byte == CHR_DOLLAR) ? 3'd1 : 3'd0);

   // line parser, one byte per cycle while not stalled
   always_comb begin
      cnt_in    = cnt_ff;
      field_in  = field_ff;
      mprog_in  = mprog_ff;
      mfound_in = mfound_ff;
      int_in    = int_ff;
      deg_in    = deg_ff;
      mm_in     = mm_ff;
      frac_in   = frac_ff;
      k_in      = k_ff;
      tfrac_in  = tfrac_ff;
      point_in  = point_ff;
      ended_in  = ended_ff;
      mask_in   = mask_ff;
      south_in  = south_ff;
      west_in   = west_ff;
      fix_in    = fix_ff;
      sat_in    = sat_ff;

      s1_in.fin       = 1'b0;
      s1_in.nl        = 1'b0;
      s1_in.kind      = (field_ff == FIELD_TIME) ? KIND_TIME :
                        ((field_ff == FIELD_LAT) ? KIND_LAT : KIND_LON);
      s1_in.int_val   = int_ff;
      s1_in.deg       = deg_ff;
      s1_in.mm        = mm_ff;
      s1_in.frac      = frac_ff;
      s1_in.k         = k_ff;
      s1_in.tfrac     = tfrac_ff;
      s1_in.cmt.match = mfound_ff;
      s1_in.cmt.mask  = mask_ff;
      s1_in.cmt.south = south_ff;
      s1_in.cmt.west  = west_ff;
      s1_in.cmt.fix   = (fin_active && field_ff == FIELD_FIX) ? fix_fin : fix_ff;
      s1_in.cmt.sat   = (fin_active && field_ff == FIELD_SAT) ? sat_fin : sat_ff;

      if (accept) begin
         if (req_rx_byte == CHR_NL) begin
            // end of line: hand over and start a fresh line
            s1_in.nl  = 1'b1;
            s1_in.fin = fin_active && (field_ff == FIELD_TIME || field_ff == FIELD_LAT ||
                                       field_ff == FIELD_LON);
            cnt_in    = '0;
            field_in  = 4'd1;
            mprog_in  = '0;
            mfound_in = 1'b0;
            int_in    = '0;
            deg_in    = '0;
            mm_in     = '0;
            frac_in   = '0;
            k_in      = '0;
            tfrac_in  = '0;
            point_in  = 1'b0;
            ended_in  = 1'b0;
            mask_in   = '0;
            south_in  = 1'b0;
            west_in   = 1'b0;
            fix_in    = '0;
            sat_in    = '0;
         end else if (cnt_ff < CW'(LINE_MAX)) begin
            cnt_in = CW'(cnt_ff + 1'b1);
            // header search
            if (mnext == MATCH_LEN) begin
               mfound_in = 1'b1;
               mprog_in  = '0;
            end else begin
               mprog_in = mnext;
            end
            if (req_rx_byte == CHR_COMMA) begin
               // field separator
               s1_in.fin = fin_active && (field_ff == FIELD_TIME || field_ff == FIELD_LAT ||
                                          field_ff == FIELD_LON);
               fix_in    = s1_in.cmt.fix;
               sat_in    = s1_in.cmt.sat;
               if (field_ff < FIELD_MAX) begin
                  field_in = 4'(field_ff + 4'd1);
               end
               int_in   = '0;
               deg_in   = '0;
               mm_in    = '0;
               frac_in  = '0;
               k_in     = '0;
               tfrac_in = '0;
               point_in = 1'b0;
               ended_in = 1'b0;
            end else if (in_range) begin
               mask_in[fidx] = 1'b1;
               if (field_ff == FIELD_NS || field_ff == FIELD_EW) begin
                  // hemisphere taken from the first character only
                  if (!mask_ff[fidx]) begin
                     if (field_ff == FIELD_NS && req_rx_byte == CHR_S) begin
                        south_in = 1'b1;
                     end
                     if (field_ff == FIELD_EW && req_rx_byte == CHR_W) begin
                        west_in = 1'b1;
                     end
                  end
               end else if (!ended_ff) begin
                  priority if (is_digit && !point_ff) begin
                     if (int_mul > {4'b0, INT_SAT}) begin
                        int_in = INT_SAT;
                        deg_in = DEG_SAT;
                        mm_in  = MM_SAT;
                     end else begin
                        int_in = int_mul[19:0];
                        deg_in = 14'(deg_ff * 14'd10 + {10'b0, tens});
                        mm_in  = 7'(ones * 7'd10 + {3'b0, dig});
                     end
                  end else if (is_digit) begin
                     if (k_ff < 3'd5) begin
                        frac_in = 17'(frac_ff * 17'd10 + {13'b0, dig});
                        k_in    = 3'(k_ff + 3'd1);
                        if (k_ff < 3'd3) begin
                           tfrac_in = 10'(tfrac_ff * 10'd10 + {6'b0, dig});
                        end
                     end
                  end else if (req_rx_byte == CHR_DOT && !point_ff) begin
                     point_in = 1'b1;
                  end else begin
                     ended_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // stage 2: minutes in 1e-5, degree term, raw time
   assign tf_prod = 20'(s1_ff.tfrac) * 20'(time_scale(s1_ff.k));
   always_comb begin
      s2_in.fin     = s1_ff.fin;
      s2_in.nl      = s1_ff.nl;
      s2_in.kind    = s1_ff.kind;
      s2_in.cmt     = s1_ff.cmt;
      s2_in.m5      = 24'(s1_ff.mm) * 24'd100000 +
                      24'(s1_ff.frac) * 24'(pow10_frac(s1_ff.k));
      s2_in.degterm = 38'(s1_ff.deg) * 38'd10000000;
      s2_in.tprod   = 31'(s1_ff.int_val) * 31'd1000 + 31'(tf_prod);
   end

   // stage 3: times 5/3 rounded, by reciprocal multiply; time saturation
   assign n3     = 27'(s2_ff.m5) * 27'd5 + 27'd1;
   assign q_prod = 54'(n3) * 54'd44739243;
   always_comb begin
      s3_in.fin     = s2_ff.fin;
      s3_in.nl      = s2_ff.nl;
      s3_in.kind    = s2_ff.kind;
      s3_in.cmt     = s2_ff.cmt;
      s3_in.degterm = s2_ff.degterm;
      s3_in.q       = q_prod[51:27];
      s3_in.tsat    = (s2_ff.tprod > 31'(TIME_SAT)) ? TIME_SAT : s2_ff.tprod[29:0];
   end

   // last stage: position saturation, shadow update and commit
   assign total  = s3_ff.degterm + 38'(s3_ff.q);
   assign limit  = (s3_ff.kind == KIND_LAT) ? LAT_SAT : LON_SAT;
   assign posv   = (total > 38'(limit)) ? limit : total[30:0];
   assign time_cur = (s3_ff.fin && s3_ff.kind == KIND_TIME) ? s3_ff.tsat : shtime_ff;
   assign lat_cur  = (s3_ff.fin && s3_ff.kind == KIND_LAT) ? posv[29:0] : shlat_ff;
   assign lon_cur  = (s3_ff.fin && s3_ff.kind == KIND_LON) ? posv : shlon_ff;
   assign commit   = s3_ff.nl && s3_ff.cmt.match && !stall;

   always_comb begin
      shtime_in = stall ? shtime_ff : time_cur;
      shlat_in  = stall ? shlat_ff : lat_cur;
      shlon_in  = stall ? shlon_ff : lon_cur;
      pubtime_in = pubtime_ff;
      publat_in  = publat_ff;
      publon_in  = publon_ff;
      pubfix_in  = pubfix_ff;
      pubsat_in  = pubsat_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         if (s3_ff.cmt.mask[0]) begin
            pubtime_in = time_cur;
         end
         if (s3_ff.cmt.mask[1]) begin
            publat_in = s3_ff.cmt.south ? 31'(31'd0 - {1'b0, lat_cur}) : {1'b0, lat_cur};
         end
         if (s3_ff.cmt.mask[3]) begin
            publon_in = s3_ff.cmt.west ? 32'(32'd0 - {1'b0, lon_cur}) : {1'b0, lon_cur};
         end
         if (s3_ff.cmt.mask[5]) begin
            pubfix_in = s3_ff.cmt.fix;
         end
         if (s3_ff.cmt.mask[6]) begin
            pubsat_in = s3_ff.cmt.sat;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         field_ff     <= 4'd1;
         mprog_ff     <= '0;
         mfound_ff    <= 1'b0;
         int_ff       <= '0;
         deg_ff       <= '0;
         mm_ff        <= '0;
         frac_ff      <= '0;
         k_ff         <= '0;
         tfrac_ff     <= '0;
         point_ff     <= 1'b0;
         ended_ff     <= 1'b0;
         mask_ff      <= '0;
         south_ff     <= 1'b0;
         west_ff      <= 1'b0;
         fix_ff       <= '0;
         sat_ff       <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         pubtime_ff   <= '0;
         publat_ff    <= '0;
         publon_ff    <= '0;
         pubfix_ff    <= '0;
         pubsat_ff    <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         field_ff     <= field_in;
         mprog_ff     <= mprog_in;
         mfound_ff    <= mfound_in;
         int_ff       <= int_in;
         deg_ff       <= deg_in;
         mm_ff        <= mm_in;
         frac_ff      <= frac_in;
         k_ff         <= k_in;
         tfrac_ff     <= tfrac_in;
         point_ff     <= point_in;
         ended_ff     <= ended_in;
         mask_ff      <= mask_in;
         south_ff     <= south_in;
         west_ff      <= west_in;
         fix_ff       <= fix_in;
         sat_ff       <= sat_in;
         if (!stall) begin
            s1_ff <= accept ? s1_in : '0;
            s2_ff <= s2_in;
            s3_ff <= s3_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         pubtime_ff   <= pubtime_in;
         publat_ff    <= publat_in;
         publon_ff    <= publon_in;
         pubfix_ff    <= pubfix_in;
         pubsat_ff    <= pubsat_in;
      end
   end

   // shadow values, only read after being written in the same line
   always_ff @(posedge clock) begin
      shtime_ff <= shtime_in;
      shlat_ff  <= shlat_in;
      shlon_ff  <= shlon_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_utc_time_milli  = pubtime_ff;
   assign rsp_latitude_e7     = publat_ff;
   assign rsp_longitude_e7    = publon_ff;
   assign rsp_fix_quality     = pubfix_ff;
   assign rsp_satellite_count = pubsat_ff;

   // checks
   `NGP_ASSERT_ALWAYS(a_cnt_limit, cnt_ff <= CW'(LINE_MAX))
   `NGP_ASSERT_ALWAYS(a_match_range, mprog_ff < MATCH_LEN)
   `NGP_ASSERT_ALWAYS(a_field_nonzero, field_ff != 4'd0)
   `NGP_ASSERT_ALWAYS(a_int_split, int_ff == 20'(deg_ff * 20'd100 + 20'(mm_ff)))
   `NGP_ASSERT_NEXT(a_nl_clears, accept && req_rx_byte == CHR_NL, cnt_ff == '0 && field_ff == 4'd1)

endmodule
